// ----- src/pee_pkg.sv -----
// Shared types and constants for the prefix expression evaluator.
`default_nettype none
package pee_pkg;
   localparam int STACK_DEPTH_DEFAULT = 64;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      KIND_NUMBER   = 3'd0,
      KIND_OPERATOR = 3'd1,
      KIND_WRONG    = 3'd2,
      KIND_OTHER    = 3'd3,
      KIND_END      = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_DIV = 2'd2,
      OP_MUL = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_BAD       = 3'd1,
      ERR_WRONGCHAR = 3'd2,
      ERR_TOKEN     = 3'd3,
      ERR_DIVZERO   = 3'd4,
      ERR_OVERFLOW  = 3'd5
   } err_type;

   // Classified token passed from front to back.
   typedef enum logic [2:0] {
      CMD_NUMBER   = 3'd0,
      CMD_OPERATOR = 3'd1,
      CMD_WRONG    = 3'd2,
      CMD_TOKEN    = 3'd3,
      CMD_END      = 3'd4
   } cmd_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [30:0] value;
      op_type      op;
   } token_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_FOLD,
      ST_DIV,
      ST_MUL,
      ST_RESP
   } state_type;
endpackage
`default_nettype wire

// ----- src/pee_if.sv -----
// Valid/ready channel interfaces for the evaluator.
`default_nettype none
interface pee_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  token_kind;
   logic [30:0] number_value;
   logic [1:0]  operator_code;
   modport source (output valid, token_kind, number_value, operator_code, input ready);
   modport sink   (input valid, token_kind, number_value, operator_code, output ready);
endinterface

interface pee_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_value;
   logic [2:0]         error_code;
   modport source (output valid, result_value, error_code, input ready);
   modport sink   (input valid, result_value, error_code, output ready);
endinterface
`default_nettype wire

// ----- src/prefix_expression_evaluator.sv -----
// Top level of the prefix expression evaluator.
//  channel | dir | payload
//  req     | in  | token_kind, number_value, operator_code
//  rsp     | out | result_value, error_code (one per end token)
// Each token passes through the queue and then the back end. A number that
// lands on a pending operator reads the stack top, then stores its operand or
// folds each level it completes: plus/minus directly, multiply via a registered
// product, divide via the iterative divider. Reset is synchronous and clears
// the stack pointer, final value and error state. A two-entry queue separates
// token intake from evaluation; a stalled result holds only end tokens.
`default_nettype none
module prefix_expression_evaluator #(
   parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEFAULT
) (
   input wire        clock,
   input wire        reset,
   pee_req_if.sink   req,
   pee_rsp_if.source rsp
);
   import pee_pkg::*;

   token_type tok;
   logic      tok_valid, tok_ready;

   pee_front u_front (.clock, .reset, .req, .tok, .tok_valid, .tok_ready);
   pee_back #(.STACK_DEPTH(STACK_DEPTH)) u_back
      (.clock, .reset, .tok, .tok_valid, .tok_ready, .rsp);
endmodule
`default_nettype wire

// ----- src/pee_front.sv -----
// Front end: classifies tokens and queues them for the back end.
`default_nettype none
module pee_front (
   input  wire              clock,
   input  wire              reset,
   pee_req_if.sink          req,
   output pee_pkg::token_type tok,
   output logic             tok_valid,
   input  wire              tok_ready
);
   import pee_pkg::*;

   token_type   queue_ff [QUEUE_DEPTH];
   logic        rd_ptr_ff, wr_ptr_ff;
   logic [1:0]  count_ff;
   token_type   cls;
   logic        push, pop;

   // Classify the raw token; unknown kinds count as unexpected tokens.
   always_comb begin
      cls.value = req.number_value;
      cls.op    = op_type'(req.operator_code);
      case (req.token_kind)
         KIND_NUMBER:   cls.cmd = CMD_NUMBER;
         KIND_OPERATOR: cls.cmd = CMD_OPERATOR;
         KIND_WRONG:    cls.cmd = CMD_WRONG;
         KIND_END:      cls.cmd = CMD_END;
         default:       cls.cmd = CMD_TOKEN;
      endcase
   end

   assign req.ready = (count_ff != 2'(QUEUE_DEPTH));
   assign push      = req.valid && req.ready;
   assign tok_valid = (count_ff != 2'd0);
   assign pop       = tok_valid && tok_ready;
   assign tok       = queue_ff[rd_ptr_ff];

   // Two-entry queue.
   always_ff @(posedge clock) begin
      if (push) queue_ff[wr_ptr_ff] <= cls;
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

`ifndef SYNTH
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'(QUEUE_DEPTH) |-> !push) else $error("queue overfill");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd0 |-> !pop) else $error("queue underflow");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif
endmodule
`default_nettype wire

// ----- src/pee_back.sv -----
// Back end: operator stack, folding, iterative divide and result register.
`default_nettype none
module pee_back #(
   parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEFAULT
) (
   input  wire                clock,
   input  wire                reset,
   input  pee_pkg::token_type tok,
   input  wire                tok_valid,
   output logic               tok_ready,
   pee_rsp_if.source          rsp
);
   import pee_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int PW = $clog2(STACK_DEPTH + 1);

   // Stack memory: operator, first operand, operand-present flag.
   logic [34:0] mem [STACK_DEPTH];
   logic [34:0] rd_data_ff;

   state_type   state_ff, state_in;
   logic [PW-1:0] sp_ff, sp_in;
   logic [31:0] val_ff, val_in;
   logic [31:0] final_ff, final_in;
   logic        final_p_ff, final_p_in;
   err_type     err_ff, err_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_val_ff, rsp_val_in;
   err_type     rsp_err_ff, rsp_err_in;

   logic        wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [34:0] wr_data;

   // Divider state.
   logic [31:0] dq_ff, dq_in, dr_ff, dr_in, dd_ff, dd_in;
   logic [5:0]  dcnt_ff, dcnt_in;
   logic        dneg_ff, dneg_in;
   logic [32:0] dtrial;
   logic [31:0] drem_sh;

   logic [31:0] op_a, ma, mb;
   logic [1:0]  top_op;
   logic        top_fp;
   logic [63:0] prod_ff;

   assign top_op = rd_data_ff[34:33];
   assign top_fp = rd_data_ff[32];
   assign op_a   = rd_data_ff[31:0];
   assign ma     = op_a[31] ? 32'd0 - op_a : op_a;
   assign mb     = val_ff[31] ? 32'd0 - val_ff : val_ff;
   assign rd_addr = AW'(sp_ff - PW'(1));
   assign drem_sh = {dr_ff[30:0], dq_ff[31]};
   assign dtrial  = {1'b0, drem_sh} - {1'b0, dd_ff};

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
      prod_ff    <= op_a * val_ff;
   end

   always_ff @(posedge clock) begin
      dq_ff <= dq_in; dr_ff <= dr_in; dd_ff <= dd_in;
      dcnt_ff <= dcnt_in; dneg_ff <= dneg_in; val_ff <= val_in;
      rsp_val_ff <= rsp_val_in; rsp_err_ff <= rsp_err_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         sp_ff        <= '0;
         final_ff     <= '0;
         final_p_ff   <= 1'b0;
         err_ff       <= ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         final_ff     <= final_in;
         final_p_ff   <= final_p_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.result_value = rsp_val_ff;
   assign rsp.error_code   = rsp_err_ff;

   // Sequencer.
   always_comb begin
      state_in = state_ff; sp_in = sp_ff; val_in = val_ff;
      final_in = final_ff; final_p_in = final_p_ff; err_in = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_val_in = rsp_val_ff; rsp_err_in = rsp_err_ff;
      dq_in = dq_ff; dr_in = dr_ff; dd_in = dd_ff; dcnt_in = dcnt_ff; dneg_in = dneg_ff;
      wr_en = 1'b0; wr_addr = rd_addr; wr_data = rd_data_ff;
      tok_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (tok_valid) begin
               case (tok.cmd)
                  CMD_NUMBER: begin
                     tok_ready = 1'b1;
                     if (err_ff == ERR_NONE) begin
                        val_in = {1'b0, tok.value};
                        if (sp_ff == '0) begin
                           if (final_p_ff) err_in = ERR_BAD;
                           else begin
                              final_in = {1'b0, tok.value}; final_p_in = 1'b1;
                           end
                        end else state_in = ST_READ;
                     end
                  end
                  CMD_OPERATOR: begin
                     tok_ready = 1'b1;
                     if (err_ff == ERR_NONE) begin
                        if (final_p_ff) err_in = ERR_BAD;
                        else if (sp_ff >= PW'(STACK_DEPTH)) err_in = ERR_OVERFLOW;
                        else begin
                           wr_en = 1'b1; wr_addr = AW'(sp_ff);
                           wr_data = {tok.op, 1'b0, 32'd0};
                           sp_in = sp_ff + PW'(1);
                        end
                     end
                  end
                  CMD_WRONG, CMD_TOKEN: begin
                     tok_ready = 1'b1;
                     if (err_ff != ERR_WRONGCHAR && err_ff != ERR_TOKEN)
                        err_in = (tok.cmd == CMD_WRONG) ? ERR_WRONGCHAR : ERR_TOKEN;
                  end
                  CMD_END: begin
                     if (!rsp_valid_ff || rsp.ready) begin
                        tok_ready = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_err_in = err_ff;
                        if (err_ff == ERR_NONE && (sp_ff != '0 || !final_p_ff))
                           rsp_err_in = ERR_BAD;
                        rsp_val_in = (rsp_err_in == ERR_NONE) ? final_ff : 32'd0;
                        sp_in = '0; final_in = '0; final_p_in = 1'b0; err_in = ERR_NONE;
                     end
                  end
                  default: tok_ready = 1'b1;
               endcase
            end
         end
         ST_READ: state_in = ST_FOLD;
         ST_FOLD: begin
            if (!top_fp) begin
               wr_en = 1'b1; wr_data = {top_op, 1'b1, val_ff};
               state_in = ST_IDLE;
            end else begin
               case (op_type'(top_op))
                  OP_ADD: begin val_in = op_a + val_ff; sp_in = sp_ff - PW'(1); end
                  OP_SUB: begin val_in = op_a - val_ff; sp_in = sp_ff - PW'(1); end
                  OP_MUL: state_in = ST_MUL;
                  OP_DIV: begin
                     if (mb == 32'd0) begin
                        err_in = ERR_DIVZERO; state_in = ST_IDLE;
                     end else begin
                        dq_in = ma; dd_in = mb; dr_in = '0; dcnt_in = 6'd0;
                        dneg_in = op_a[31] ^ val_ff[31];
                        state_in = ST_DIV;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
               if (op_type'(top_op) == OP_ADD || op_type'(top_op) == OP_SUB)
                  state_in = (sp_ff == PW'(1)) ? ST_IDLE : ST_READ;
               if ((op_type'(top_op) == OP_ADD || op_type'(top_op) == OP_SUB)
                   && sp_ff == PW'(1)) begin
                  final_in = val_in; final_p_in = 1'b1;
               end
            end
         end
         ST_MUL: begin
            val_in = prod_ff[31:0]; sp_in = sp_ff - PW'(1);
            if (sp_ff == PW'(1)) begin
               final_in = prod_ff[31:0]; final_p_in = 1'b1; state_in = ST_IDLE;
            end else state_in = ST_READ;
         end
         ST_DIV: begin
            // One quotient bit per cycle, restoring.
            if (!dtrial[32]) begin
               dr_in = dtrial[31:0]; dq_in = {dq_ff[30:0], 1'b1};
            end else begin
               dr_in = drem_sh; dq_in = {dq_ff[30:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 6'd1;
            if (dcnt_ff == 6'd31) begin
               val_in = dneg_ff ? 32'd0 - dq_in : dq_in;
               sp_in = sp_ff - PW'(1);
               if (sp_ff == PW'(1)) begin
                  final_in = val_in; final_p_in = 1'b1; state_in = ST_IDLE;
               end else state_in = ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTH
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= PW'(STACK_DEPTH)) else $error("stack pointer out of range");
   a_fold_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> sp_ff != '0) else $error("fold on empty stack");
   a_busy_no_take: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !tok_ready) else $error("token taken while busy");
`endif
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the prefix expression evaluator.
`timescale 1ns / 100ps
module testbench;
   import pee_pkg::*;

   localparam int DEPTH = STACK_DEPTH_DEFAULT;
   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct {
      logic signed [31:0] value;
      err_type            err;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   longint cycles = 0;
   int mismatches = 0;
   int stall_max = 3;

   pee_req_if req ();
   pee_rsp_if rsp ();

   prefix_expression_evaluator u_dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   always #2 clock = ~clock;

   // Predictor state
   op_type      stk_op [DEPTH];
   logic [31:0] stk_lhs [DEPTH];
   bit          stk_has [DEPTH];
   int          depth_used;
   logic [31:0] total;
   bit          total_set;
   err_type     err_held;
   answer_type  answers[$];

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic void clear_expr();
      depth_used = 0;
      total = '0;
      total_set = 0;
      err_held = ERR_NONE;
   endfunction

   function automatic void note_eval_err(err_type e);
      if (err_held == ERR_NONE) err_held = e;
   endfunction

   function automatic void note_lex_err(err_type e);
      if (err_held != ERR_WRONGCHAR && err_held != ERR_TOKEN) err_held = e;
   endfunction

   // Signed divide truncating toward zero, wrapping on min / -1
   function automatic logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma, mb, q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q = ma / mb;
      return (a[31] != b[31]) ? -q : q;
   endfunction

   function automatic void push_number(logic [31:0] v);
      int t;
      forever begin
         if (depth_used == 0) begin
            if (total_set) note_eval_err(ERR_BAD);
            else begin
               total = v;
               total_set = 1;
            end
            return;
         end
         t = depth_used - 1;
         if (!stk_has[t]) begin
            stk_lhs[t] = v;
            stk_has[t] = 1;
            return;
         end
         case (stk_op[t])
            OP_ADD: v = stk_lhs[t] + v;
            OP_SUB: v = stk_lhs[t] - v;
            OP_DIV: begin
               if (v == 0) begin
                  note_eval_err(ERR_DIVZERO);
                  return;
               end
               v = quotient(stk_lhs[t], v);
            end
            default: v = stk_lhs[t] * v;
         endcase
         depth_used--;
      end
   endfunction

   function automatic void evaluate_token(logic [2:0] kind, logic [30:0] num, logic [1:0] op);
      answer_type a;
      case (kind)
         KIND_NUMBER: if (err_held == ERR_NONE) push_number({1'b0, num});
         KIND_OPERATOR: begin
            if (err_held == ERR_NONE) begin
               if (total_set) note_eval_err(ERR_BAD);
               else if (depth_used >= DEPTH) note_eval_err(ERR_OVERFLOW);
               else begin
                  stk_op[depth_used] = op_type'(op);
                  stk_has[depth_used] = 0;
                  depth_used++;
               end
            end
         end
         KIND_WRONG: note_lex_err(ERR_WRONGCHAR);
         KIND_END: begin
            a.err = err_held;
            a.value = '0;
            if (a.err == ERR_NONE && (depth_used != 0 || !total_set)) a.err = ERR_BAD;
            if (a.err == ERR_NONE) a.value = total;
            answers.insert(answers.size(), a);
            clear_expr();
         end
         default: note_lex_err(ERR_TOKEN);
      endcase
   endfunction

   // Send one token; prediction made at the transfer edge
   task automatic send_token(logic [2:0] kind, logic [30:0] num, logic [1:0] op);
      int g;
      g = gap_len();
      if (g > 0) begin
         req.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req.valid <= 1'b1;
      req.token_kind <= kind;
      req.number_value <= num;
      req.operator_code <= op;
      do @(posedge clock); while (!req.ready);
      evaluate_token(kind, num, op);
      @(negedge clock);
   endtask

   task automatic send_num(logic [30:0] v);
      send_token(KIND_NUMBER, v, 2'($urandom));
   endtask

   task automatic send_op(op_type o);
      send_token(KIND_OPERATOR, 31'($urandom), o);
   endtask

   task automatic send_end();
      send_token(KIND_END, 31'($urandom), 2'($urandom));
   endtask

   function automatic logic [30:0] rand_num();
      case ($urandom_range(0, 4))
         0: return 31'($urandom_range(0, 3));
         1: return 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
         2: return 31'($urandom_range(0, 100));
         default: return 31'($urandom);
      endcase
   endfunction

   // Random well-formed prefix expression, optionally with a fault
   task automatic send_random_expr(int max_ops);
      int ops, need, fault;
      ops = $urandom_range(0, max_ops);
      need = 1;
      fault = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 5) : 0;
      while (need > 0) begin
         if (fault == 1 && $urandom_range(0, 7) == 0) break;
         if (fault == 2 && $urandom_range(0, 7) == 0)
            send_token(KIND_WRONG, rand_num(), 2'($urandom));
         if (fault == 3 && $urandom_range(0, 7) == 0)
            send_token(3'($urandom_range(3, 7)), rand_num(), 2'($urandom));
         if (ops > 0 && $urandom_range(0, 1)) begin
            send_op(op_type'(2'($urandom)));
            ops--;
            need++;
         end else begin
            send_num(rand_num());
            need--;
         end
      end
      if (fault == 4) send_num(rand_num());
      if (fault == 5) send_op(op_type'(2'($urandom)));
      send_end();
   endtask

   // Result checker
   always @(posedge clock) begin
      answer_type a;
      if (!reset && rsp.valid && rsp.ready) begin
         if (answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result value=%0d err=%0d", rsp.result_value, rsp.error_code);
         end else begin
            a = answers.pop_front();
            if (rsp.result_value !== a.value || rsp.error_code !== a.err) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected value=%0d err=%0d, got value=%0d err=%0d",
                           a.value, a.err, rsp.result_value, rsp.error_code);
            end
         end
      end
   end

   // Result-side stalls
   always @(negedge clock) begin
      if (stall_max == 0 || $urandom_range(0, 3) != 0) rsp.ready <= 1'b1;
      else rsp.ready <= ($urandom_range(0, stall_max) == 0);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic test_directed_basics();
      send_num(31'h7FFF_FFFF); send_end();
      send_num(31'd0); send_end();
      send_op(OP_ADD); send_num(31'h7FFF_FFFF); send_num(31'h7FFF_FFFF); send_end();
      send_op(OP_SUB); send_num(31'd0); send_num(31'h7FFF_FFFF); send_end();
      send_op(OP_MUL); send_num(31'h7FFF_FFFF); send_num(31'h5555_5555); send_end();
      send_op(OP_DIV); send_num(31'd7); send_num(31'd2); send_end();
   endtask

   task automatic test_division_edges();
      // negative dividend, most negative divided by minus one, and divide by zero
      send_op(OP_DIV); send_op(OP_SUB); send_num(31'd0); send_num(31'd7); send_num(31'd2);
      send_end();
      send_op(OP_DIV); send_op(OP_SUB); send_num(31'd0); send_op(OP_ADD);
      send_num(31'h7FFF_FFFF); send_num(31'd1);
      send_op(OP_SUB); send_num(31'd0); send_num(31'd1); send_end();
      send_op(OP_DIV); send_num(31'd5); send_num(31'd0); send_end();
   endtask

   task automatic test_error_cases();
      send_num(31'd1); send_num(31'd2); send_end();
      send_num(31'd1); send_op(OP_ADD); send_end();
      send_op(OP_ADD); send_num(31'd1); send_end();
      send_end();
      send_op(OP_DIV); send_num(31'd1); send_num(31'd0);
      send_token(KIND_WRONG, 31'd0, 2'd0); send_token(KIND_OTHER, 31'd0, 2'd0); send_end();
      send_token(KIND_OTHER, 31'd0, 2'd0); send_token(KIND_WRONG, 31'd0, 2'd0); send_end();
      send_token(3'd7, 31'h7FFF_FFFF, 2'd3); send_num(31'd3); send_end();
   endtask

   task automatic test_stack_limit();
      repeat (DEPTH) send_op(OP_ADD);
      repeat (DEPTH + 1) send_num(rand_num());
      send_end();
      repeat (DEPTH + 1) send_op(OP_MUL);
      send_end();
   endtask

   task automatic test_random_exprs();
      int sent;
      sent = 0;
      while (sent < 140) begin
         if (sent == 60) stall_max = 0;
         if (sent == 90) stall_max = 30;
         send_random_expr((sent % 25 == 0) ? 12 : 4);
         sent++;
      end
   endtask

   initial begin
      longint t0;
      req.valid = 1'b0;
      req.token_kind = '0;
      req.number_value = '0;
      req.operator_code = '0;
      rsp.ready = 1'b0;
      clear_expr();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_basics();
      test_division_edges();
      test_error_cases();
      test_stack_limit();
      test_random_exprs();
      req.valid <= 1'b0;
      t0 = cycles;
      while (answers.size() != 0 && cycles - t0 < 200000) @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatches == 0 && answers.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
